// ===== hw/rtl/bdpt_pkg.sv =====
// shared types and constants for the button debounce press timer
`default_nettype none

package bdpt_pkg;

  localparam int unsigned SettleW = 8;
  localparam int unsigned OutDurW = 32;

  localparam logic [SettleW-1:0] SettleReset = 8'd40;

  typedef struct packed {
    logic               pressed_event;
    logic               released_event;
    logic               stable_down;
    logic [OutDurW-1:0] press_duration;
  } bdpt_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdpt_if.sv =====
// channel interfaces: key samples, debounce events and settle time writes
`default_nettype none

interface bdpt_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

interface bdpt_evt_if import bdpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               pressed_event;
  logic               released_event;
  logic               stable_down;
  logic [OutDurW-1:0] press_duration;

  modport source (output valid, output pressed_event, output released_event,
                  output stable_down, output press_duration, input ready);
  modport sink (input valid, input pressed_event, input released_event,
                input stable_down, input press_duration, output ready);
endinterface

interface bdpt_cfg_if import bdpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SettleW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/button_debounce_press_timer_top.sv =====
// top level: four-state key debouncer with saturating press duration timer
//
//   channel  dir  payload                                          transfer when
//   key_i    in   key_level (0 = pressed)                          valid && ready
//   evt_o    out  pressed_event, released_event, stable_down,      valid && ready
//                 press_duration[31:0]
//   cfg_i    in   data = settle_ticks[7:0]                         valid && ready
//
// one key sample a cycle while key_i.ready is high: the debounce state updates at
// the sample transfer and the result is registered at that same edge, showing on
// evt_o from the next cycle unless it queues in the skid. the two-entry buffer
// lets samples flow while a result waits; key_i.ready drops only when both are full.
// reset puts the machine in the up state, clears the counters and loads a
// settle time of 40 ticks. cfg_i is always ready.
`default_nettype none

module button_debounce_press_timer_top import bdpt_pkg::*; #(
  parameter int unsigned DURATION_WIDTH = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  bdpt_key_if.sink     key_i,
  bdpt_evt_if.source   evt_o,
  bdpt_cfg_if.sink     cfg_i
);

  typedef enum logic [1:0] {
    ST_UP,
    ST_FALLING,
    ST_DOWN,
    ST_RISING
  } dbnc_state_e;

  dbnc_state_e               state_q, state_d;
  logic [SettleW-1:0]        settle_ticks_q;
  logic [SettleW-1:0]        settle_cnt_q, settle_cnt_d;
  logic [DURATION_WIDTH-1:0] held_q, held_d;

  bdpt_result_t res_d;
  bdpt_result_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;

  logic                      in_xfer, out_xfer;
  logic                      level_low;
  logic                      settle_done;
  logic [SettleW-1:0]        settle_inc;
  logic [DURATION_WIDTH-1:0] held_inc;
  logic [63:0]               dur_ext;

  assign key_i.ready = ~skid_valid_q;
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = key_i.valid & key_i.ready;
  assign out_xfer    = out_valid_q & evt_o.ready;
  assign level_low   = ~key_i.key_level;

  assign settle_inc  = settle_cnt_q + SettleW'(1);
  // a settle time of zero behaves as one
  assign settle_done = settle_inc >= settle_ticks_q;

  always_comb begin
    held_inc = held_q;
    if ((state_q == ST_DOWN || state_q == ST_RISING) && held_q != '1) begin
      held_inc = held_q + DURATION_WIDTH'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    settle_cnt_d = settle_cnt_q;
    held_d       = held_inc;
    res_d        = '0;
    unique case (state_q)
      ST_UP: begin
        if (level_low) begin
          state_d      = ST_FALLING;
          settle_cnt_d = '0;
        end
      end
      ST_FALLING: begin
        settle_cnt_d = settle_inc;
        if (settle_done) begin
          settle_cnt_d = '0;
          if (level_low) begin
            state_d             = ST_DOWN;
            held_d              = '0;
            res_d.pressed_event = 1'b1;
          end else begin
            state_d = ST_UP;
          end
        end
      end
      ST_DOWN: begin
        if (!level_low) begin
          state_d      = ST_RISING;
          settle_cnt_d = '0;
        end
      end
      ST_RISING: begin
        settle_cnt_d = settle_inc;
        if (settle_done) begin
          settle_cnt_d = '0;
          if (!level_low) begin
            state_d              = ST_UP;
            res_d.released_event = 1'b1;
          end else begin
            state_d = ST_DOWN;
          end
        end
      end
      default: state_d = ST_UP;
    endcase
    dur_ext              = 64'(held_inc);
    res_d.press_duration = res_d.released_event ? dur_ext[OutDurW-1:0] : '0;
    res_d.stable_down    = (state_d == ST_DOWN) || (state_d == ST_RISING);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_UP;
      settle_cnt_q   <= '0;
      held_q         <= '0;
      settle_ticks_q <= SettleReset;
      out_q          <= '0;
      skid_q         <= '0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        settle_ticks_q <= cfg_i.data;
      end
      if (in_xfer) begin
        state_q      <= state_d;
        settle_cnt_q <= settle_cnt_d;
        held_q       <= held_d;
      end
      if (out_xfer) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end else if (in_xfer) begin
          out_q <= res_d;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (in_xfer) begin
        if (!out_valid_q) begin
          out_q       <= res_d;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res_d;
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  assign evt_o.valid          = out_valid_q;
  assign evt_o.pressed_event  = out_q.pressed_event;
  assign evt_o.released_event = out_q.released_event;
  assign evt_o.stable_down    = out_q.stable_down;
  assign evt_o.press_duration = out_q.press_duration;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.pressed_event && out_q.released_event))
    else $error("press and release in one result");

  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.pressed_event || out_q.released_event))
      |-> (out_q.stable_down == out_q.pressed_event))
    else $error("event disagrees with debounced level");

  a_duration_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.released_event) |-> (out_q.press_duration == '0))
    else $error("duration shown without release");

endmodule

`default_nettype wire
